>>> src/slsc_pkg.sv
package slsc_pkg;

    // Fixed field widths of the scan and result items
    localparam int NUM_SENSORS = 4;
    localparam int DIST_W      = 13;
    localparam int COUNT_W     = 3;
    localparam int STATUS_W    = 2;
    localparam int SEL_W       = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_THRESHOLD  = 2'd1;

    localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST = 13'd100;
    localparam logic [DIST_W-1:0] FAR_THRESHOLD_RST  = 13'd150;

    // Stack status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DISCONT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEGRADED = 2'd2;

    typedef logic [DIST_W-1:0]      dist_t;
    typedef logic [NUM_SENSORS-1:0] mask_t;

    typedef struct packed {
        mask_t online_mask;
        mask_t valid_mask;
        dist_t distance_0;
        dist_t distance_1;
        dist_t distance_2;
        dist_t distance_3;
    } scan_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  stack_count;
        logic [STATUS_W-1:0] stack_status;
        mask_t               present_levels;
        mask_t               unknown_levels;
    } result_item_t;

    // Pick one sensor's distance out of a scan
    function automatic dist_t get_distance(scan_item_t item, logic [SEL_W-1:0] sel);
        dist_t d;
        unique case (sel)
            2'd0:    d = item.distance_0;
            2'd1:    d = item.distance_1;
            2'd2:    d = item.distance_2;
            default: d = item.distance_3;
        endcase
        return d;
    endfunction

endpackage

>>> src/slsc_scan_if.sv
interface slsc_scan_if import slsc_pkg::*; ();
    logic       valid;
    logic       ready;
    scan_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/slsc_result_if.sv
interface slsc_result_if import slsc_pkg::*; ();
    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/slsc_cfg_if.sv
interface slsc_cfg_if import slsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> src/slsc_flag_update.sv
module slsc_flag_update import slsc_pkg::*; #(
    parameter int LEVELS = 4
) (
    input  scan_item_t        scan,
    input  dist_t             near_threshold,
    input  dist_t             far_threshold,
    input  logic [LEVELS-1:0] flags,
    output logic [LEVELS-1:0] flags_next
);

    // Hysteresis per level; invalid online levels clear, offline levels keep their flag
    always_comb
    begin
        dist_t d;
        flags_next = flags;
        for (int i = 0; i < LEVELS; i++)
        begin
            d = get_distance(scan, SEL_W'(i));
            if (scan.online_mask[i])
            begin
                if (!scan.valid_mask[i])
                    flags_next[i] = 1'b0;
                else if (d < near_threshold)
                    flags_next[i] = 1'b1;
                else if (d > far_threshold)
                    flags_next[i] = 1'b0;
            end
        end
    end

endmodule

>>> src/slsc_classify.sv
module slsc_classify import slsc_pkg::*; #(
    parameter int LEVELS = 4
) (
    input  logic [LEVELS-1:0] flags,
    input  mask_t             online_mask,
    output result_item_t      result
);

    logic [LEVELS-1:0] online;
    logic [LEVELS-1:0] present;
    logic [LEVELS-1:0] absent;
    logic [LEVELS-1:0] unknown;

    assign online  = online_mask[LEVELS-1:0];
    assign present = flags & online;
    assign absent  = online & ~flags;
    assign unknown = ~online;

    always_comb
    begin
        logic [COUNT_W-1:0] count;
        logic               fault;
        logic               stopped;
        logic               ambiguous;
        count     = '0;
        fault     = 1'b0;
        stopped   = 1'b0;
        ambiguous = 1'b0;

        // Topmost present level, as count = top + 1
        for (int i = 0; i < LEVELS; i++)
        begin
            if (present[i])
                count = COUNT_W'(i + 1);
        end

        // Gap below the top, and unknown levels above it up to the first gap
        for (int i = 0; i < LEVELS; i++)
        begin
            if (absent[i] && ((i + 1) < int'(count)))
                fault = 1'b1;
            if ((i >= int'(count)) && !stopped)
            begin
                if (absent[i])
                    stopped = 1'b1;
                else if (unknown[i])
                    ambiguous = 1'b1;
            end
        end

        result.present_levels = NUM_SENSORS'(present);
        result.unknown_levels = NUM_SENSORS'(unknown);
        if (fault)
        begin
            result.stack_count  = '0;
            result.stack_status = STATUS_DISCONT;
        end
        else
        begin
            result.stack_count  = count;
            result.stack_status = ambiguous ? STATUS_DEGRADED : STATUS_OK;
        end
    end

endmodule

>>> src/stacked_level_sensor_classifier_top.sv
// Stacked level sensor classifier. Each transfer on in_ch is one scan of the
// stacked distance sensors (level 0 at the bottom); each scan gives exactly one
// transfer on out_ch with the stack count, status and the present and unknown
// level masks. A scan is registered, then the hysteresis update and the stack
// classification run combinationally into the result register, and a new scan
// is taken every cycle unless out_ch stalls; the per-level present flags are
// updated as a scan moves into the result register, which orders them with the
// scans. Thresholds are written through cfg_ch (index 0 near, 1 far; other
// indexes ignored) and should only be changed while no scan is in flight.
// LEVELS (2 to 4) sets how many sensors are used; higher bits are ignored.
module stacked_level_sensor_classifier_top import slsc_pkg::*; #(
    parameter int LEVELS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    slsc_scan_if.sink     in_ch,
    slsc_result_if.source out_ch,
    slsc_cfg_if.sink      cfg_ch
);

    logic              scan_valid_reg;
    scan_item_t        scan_reg;
    logic              out_valid_reg;
    result_item_t      out_data_reg;
    logic [LEVELS-1:0] flags_reg;
    logic [LEVELS-1:0] flags_next;
    dist_t             near_reg;
    dist_t             far_reg;
    result_item_t      result_next;
    logic              out_free;
    logic              scan_advance;

    // Handshake: result register frees the scan stage, scan stage frees input
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign scan_advance = scan_valid_reg && out_free;
    assign in_ch.ready  = !scan_valid_reg || out_free;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    slsc_flag_update #(
        .LEVELS(LEVELS)
    ) u_flag_update (
        .scan           (scan_reg),
        .near_threshold (near_reg),
        .far_threshold  (far_reg),
        .flags          (flags_reg),
        .flags_next     (flags_next)
    );

    slsc_classify #(
        .LEVELS(LEVELS)
    ) u_classify (
        .flags       (flags_next),
        .online_mask (scan_reg.online_mask),
        .result      (result_next)
    );

    // Control state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            flags_reg      <= '0;
        end
        else
        begin
            if (in_ch.ready)
                scan_valid_reg <= in_ch.valid;
            if (out_free)
                out_valid_reg <= scan_valid_reg;
            if (scan_advance)
                flags_reg <= flags_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            scan_reg <= in_ch.data;
        if (scan_advance)
            out_data_reg <= result_next;
    end

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_THRESHOLD_RST;
            far_reg  <= FAR_THRESHOLD_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_NEAR_THRESHOLD: near_reg <= cfg_ch.wdata;
                CFG_FAR_THRESHOLD:  far_reg  <= cfg_ch.wdata;
                default:            ;
            endcase
        end
    end

endmodule
